/* rtl/rfc_pkg.sv */
// Shared types and constants for the region fill classifier.
package rfc_pkg;

  // Fixed-point fraction bits of all coordinates and values
  localparam int FRAC_BITS = 16;

  // Bit positions of the truncated product slice
  localparam int U_LO = FRAC_BITS;
  localparam int U_HI = FRAC_BITS + 31;

  // Region shape codes
  typedef enum logic [1:0] {
    SHAPE_RECT     = 2'd0,
    SHAPE_CIRCLE   = 2'd1,
    SHAPE_POINT    = 2'd2,
    SHAPE_FILL_ALL = 2'd3
  } rfc_shape_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_REGION_SHAPE  = 3'd0,
    CFG_REGION_X_LOW  = 3'd1,
    CFG_REGION_X_HIGH = 3'd2,
    CFG_REGION_Y_LOW  = 3'd3,
    CFG_REGION_Y_HIGH = 3'd4,
    CFG_REGION_RADIUS = 3'd5,
    CFG_FILL_ENERGY   = 3'd6,
    CFG_FILL_DENSITY  = 3'd7
  } rfc_cfg_idx_t;

  // One input cell
  typedef struct packed {
    logic signed [31:0] vertex_x_low;
    logic signed [31:0] vertex_x_high;
    logic signed [31:0] vertex_y_low;
    logic signed [31:0] vertex_y_high;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic        [31:0] current_energy;
    logic        [31:0] current_density;
    logic               interior_cell;
  } rfc_in_t;

  // One result
  typedef struct packed {
    logic [31:0] new_energy;
    logic [31:0] new_density;
    logic [31:0] cell_u;
    logic        u_written;
    logic        region_hit;
  } rfc_out_t;

endpackage

/* rtl/rfc_ifs.sv */
// Channel interfaces of the region fill classifier: cell input, result, configuration.
interface rfc_in_if;
  logic             valid;
  logic             ready;
  rfc_pkg::rfc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rfc_out_if;
  logic              valid;
  logic              ready;
  rfc_pkg::rfc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* rtl/region_fill_classifier.sv */
// Top level of the region fill classifier: three-stage cell pipeline and config registers.
//
//   channel  | direction | payload
//   in_ch    | sink      | cell bounds, centre, energy, density, interior flag
//   out_ch   | source    | new energy, new density, cell_u, u_written, region_hit
//   cfg_ch   | sink      | 3-bit register index, 32-bit write data
//
// One cell per cycle sustained while out_ch.ready is high; a taken cell goes through the
// input, multiply and compare/select result registers, the last driving out_ch.valid.
// Each stage loads when it is empty or the stage after it moves, so bubbles collapse and
// a new transaction is taken while a finished result waits on out_ch.ready, if a stage is empty.
// Reset clears the stage valid bits and the configuration (shape resets to fill-all).
// cfg_ch is always ready; derived radius squared and fill product are registered.
module region_fill_classifier (
  input  logic     clk,
  input  logic     rst_n,
  rfc_in_if.sink   in_ch,
  rfc_out_if.source out_ch,
  rfc_cfg_if.sink  cfg_ch
);
  import rfc_pkg::*;

  // Configuration registers
  rfc_shape_t         shape_r;
  logic signed [31:0] rx_low_r, rx_high_r, ry_low_r, ry_high_r;
  logic        [30:0] radius_r;
  logic        [31:0] fill_energy_r, fill_density_r;
  logic        [61:0] r2_r;
  logic        [63:0] fill_prod_r;

  // Pipeline registers
  logic        a_valid_r, b_valid_r, c_valid_r;
  rfc_in_t     a_cell_r;
  logic        b_rect_hit_r, b_point_hit_r, b_interior_r;
  logic [63:0] b_dx2_r, b_dy2_r, b_prod_r;
  logic [31:0] b_energy_r, b_density_r;
  rfc_out_t    c_res_r;

  // Stage enables
  logic c_en, b_en, a_en;

  // Stage B logic
  logic signed [32:0] dx, dy;
  logic        [32:0] ax_w, ay_w;
  logic        [31:0] ax, ay;
  logic        [63:0] dx2_nxt, dy2_nxt, prod_nxt;
  logic               rect_hit_nxt, point_hit_nxt;

  // Stage C logic
  logic        circle_hit;
  logic        hit;
  logic        write_u;
  logic [64:0] dsum;
  logic [63:0] prod_sel;
  logic [31:0] u_sat;
  rfc_out_t    res_nxt;

  assign c_en        = !c_valid_r || out_ch.ready;
  assign b_en        = !b_valid_r || c_en;
  assign a_en        = !a_valid_r || b_en;
  assign in_ch.ready = a_en;
  assign cfg_ch.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r        <= SHAPE_FILL_ALL;
      rx_low_r       <= '0;
      rx_high_r      <= '0;
      ry_low_r       <= '0;
      ry_high_r      <= '0;
      radius_r       <= '0;
      fill_energy_r  <= '0;
      fill_density_r <= '0;
    end else if (cfg_ch.valid) begin
      case (rfc_cfg_idx_t'(cfg_ch.index))
        CFG_REGION_SHAPE:  shape_r        <= rfc_shape_t'(cfg_ch.wdata[1:0]);
        CFG_REGION_X_LOW:  rx_low_r       <= cfg_ch.wdata;
        CFG_REGION_X_HIGH: rx_high_r      <= cfg_ch.wdata;
        CFG_REGION_Y_LOW:  ry_low_r       <= cfg_ch.wdata;
        CFG_REGION_Y_HIGH: ry_high_r      <= cfg_ch.wdata;
        CFG_REGION_RADIUS: radius_r       <= cfg_ch.wdata[30:0];
        CFG_FILL_ENERGY:   fill_energy_r  <= cfg_ch.wdata;
        CFG_FILL_DENSITY:  fill_density_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // Precompute config-only products
  always_ff @(posedge clk) begin
    r2_r        <= radius_r * radius_r;
    fill_prod_r <= fill_energy_r * fill_density_r;
  end

  // Advance stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_en) a_valid_r <= in_ch.valid;
      if (b_en) b_valid_r <= a_valid_r;
      if (c_en) c_valid_r <= b_valid_r;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (a_en && in_ch.valid) a_cell_r <= in_ch.data;
  end

  // Stage B: distances, squares, rectangle and point tests, current product
  always_comb begin
    dx            = {a_cell_r.centre_x[31], a_cell_r.centre_x} - {rx_low_r[31], rx_low_r};
    dy            = {a_cell_r.centre_y[31], a_cell_r.centre_y} - {ry_low_r[31], ry_low_r};
    ax_w          = dx[32] ? 33'(-dx) : 33'(dx);
    ay_w          = dy[32] ? 33'(-dy) : 33'(dy);
    ax            = ax_w[31:0];
    ay            = ay_w[31:0];
    dx2_nxt       = ax * ax;
    dy2_nxt       = ay * ay;
    prod_nxt      = a_cell_r.current_energy * a_cell_r.current_density;
    rect_hit_nxt  = (a_cell_r.vertex_x_high >= rx_low_r) &&
                    (a_cell_r.vertex_x_low  <  rx_high_r) &&
                    (a_cell_r.vertex_y_high >= ry_low_r) &&
                    (a_cell_r.vertex_y_low  <  ry_high_r);
    point_hit_nxt = (a_cell_r.vertex_x_low == rx_low_r) &&
                    (a_cell_r.vertex_y_low == ry_low_r);
  end

  always_ff @(posedge clk) begin
    if (b_en && a_valid_r) begin
      b_dx2_r       <= dx2_nxt;
      b_dy2_r       <= dy2_nxt;
      b_prod_r      <= prod_nxt;
      b_rect_hit_r  <= rect_hit_nxt;
      b_point_hit_r <= point_hit_nxt;
      b_energy_r    <= a_cell_r.current_energy;
      b_density_r   <= a_cell_r.current_density;
      b_interior_r  <= a_cell_r.interior_cell;
    end
  end

  // Stage C: circle compare, shape select, replace values, saturate u
  always_comb begin
    dsum       = {1'b0, b_dx2_r} + {1'b0, b_dy2_r};
    circle_hit = (b_dx2_r <= {2'b00, r2_r}) && (b_dy2_r <= {2'b00, r2_r}) &&
                 (dsum <= {3'b000, r2_r});
    case (shape_r)
      SHAPE_RECT:     hit = b_rect_hit_r;
      SHAPE_CIRCLE:   hit = circle_hit;
      SHAPE_POINT:    hit = b_point_hit_r;
      SHAPE_FILL_ALL: hit = 1'b1;
      default:        hit = 1'b1;
    endcase
    write_u  = b_interior_r && (shape_r != SHAPE_FILL_ALL);
    prod_sel = hit ? fill_prod_r : b_prod_r;
    u_sat    = (|prod_sel[63:U_HI+1]) ? '1 : prod_sel[U_HI:U_LO];

    res_nxt.new_energy  = hit ? fill_energy_r : b_energy_r;
    res_nxt.new_density = hit ? fill_density_r : b_density_r;
    res_nxt.cell_u      = write_u ? u_sat : '0;
    res_nxt.u_written   = write_u;
    res_nxt.region_hit  = hit;
  end

  always_ff @(posedge clk) begin
    if (c_en && b_valid_r) c_res_r <= res_nxt;
  end

  assign out_ch.valid = c_valid_r;
  assign out_ch.data  = c_res_r;

  // An accepted transaction always lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> a_valid_r)
    else $error("accepted cell did not reach the input stage");

  // A result without u carries zero in cell_u
  a_u_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.u_written |-> out_ch.data.cell_u == '0)
    else $error("cell_u nonzero while u_written is low");

  // A stalled output freezes a full middle stage
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r && !out_ch.ready && b_valid_r |=> b_valid_r && $stable(b_prod_r))
    else $error("middle stage lost its item under output stall");

endmodule

/* test/region_fill_classifier_tb.sv */
// Self-checking testbench for the region fill classifier: directed and random cells per region.
`timescale 1ns / 1ps

module region_fill_classifier_tb;
  import rfc_pkg::*;

  localparam logic [31:0] ONE         = 32'h0001_0000;
  localparam int          STALL_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst_n;

  rfc_in_if  in_ch ();
  rfc_out_if out_ch ();
  rfc_cfg_if cfg_ch ();

  region_fill_classifier u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Region copy and fill-cell predictor, with the queue of cells still to come out
  class fill_scoreboard;
    rfc_shape_t  shape;
    int          x_low, x_high, y_low, y_high;
    logic [30:0] radius;
    logic [31:0] fill_e, fill_d;
    rfc_out_t    pending_fills[$];
    int          fails;

    function new();
      shape  = SHAPE_FILL_ALL;
      x_low  = 0;
      x_high = 0;
      y_low  = 0;
      y_high = 0;
      radius = '0;
      fill_e = '0;
      fill_d = '0;
      fails  = 0;
    endfunction

    // Mirror one register write, dropping bits above the register width
    function void write_reg(rfc_cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_REGION_SHAPE:  shape  = rfc_shape_t'(v[1:0]);
        CFG_REGION_X_LOW:  x_low  = v;
        CFG_REGION_X_HIGH: x_high = v;
        CFG_REGION_Y_LOW:  y_low  = v;
        CFG_REGION_Y_HIGH: y_high = v;
        CFG_REGION_RADIUS: radius = v[30:0];
        CFG_FILL_ENERGY:   fill_e = v;
        CFG_FILL_DENSITY:  fill_d = v;
        default: ;
      endcase
    endfunction

    function rfc_out_t classify_cell(rfc_in_t c);
      rfc_out_t          r;
      int                vxl, vxh, vyl, vyh;
      longint            ax, ay;
      longint unsigned   ux, uy, dx2, dy2, r2, prod;
      logic              hit;
      vxl = c.vertex_x_low;
      vxh = c.vertex_x_high;
      vyl = c.vertex_y_low;
      vyh = c.vertex_y_high;
      case (shape)
        SHAPE_RECT: begin
          hit = (vxh >= x_low) && (vxl < x_high) && (vyh >= y_low) && (vyl < y_high);
        end
        SHAPE_CIRCLE: begin
          // exact squared distance against squared radius
          ax = longint'(int'(c.centre_x)) - longint'(x_low);
          ay = longint'(int'(c.centre_y)) - longint'(y_low);
          if (ax < 0) ax = -ax;
          if (ay < 0) ay = -ay;
          ux  = ax;
          uy  = ay;
          dx2 = ux * ux;
          dy2 = uy * uy;
          r2  = {33'b0, radius} * {33'b0, radius};
          hit = (dx2 <= r2) && (dy2 <= r2) && (dx2 + dy2 <= r2);
        end
        SHAPE_POINT: begin
          hit = (vxl == x_low) && (vyl == y_low);
        end
        default: begin
          hit = 1'b1;
        end
      endcase
      r.new_energy   = hit ? fill_e : c.current_energy;
      r.new_density  = hit ? fill_d : c.current_density;
      r.region_hit   = hit;
      r.u_written    = c.interior_cell && (shape != SHAPE_FILL_ALL);
      r.cell_u       = '0;
      if (r.u_written) begin
        prod = ({32'b0, r.new_energy} * {32'b0, r.new_density}) >> FRAC_BITS;
        r.cell_u = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
      end
      return r;
    endfunction

    function void note_cell(rfc_in_t c);
      pending_fills.push_back(classify_cell(c));
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, actual %h", name, exp_v, act_v);
        fails++;
      end
    endfunction

    function void check_fill(rfc_out_t got);
      rfc_out_t exp_r;
      if (pending_fills.size() == 0) begin
        $error("result with no cell outstanding: %h", got);
        fails++;
        return;
      end
      exp_r = pending_fills.pop_front();
      compare_field("new_energy", exp_r.new_energy, got.new_energy);
      compare_field("new_density", exp_r.new_density, got.new_density);
      compare_field("cell_u", exp_r.cell_u, got.cell_u);
      compare_field("u_written", exp_r.u_written, got.u_written);
      compare_field("region_hit", exp_r.region_hit, got.region_hit);
    endfunction
  endclass

  fill_scoreboard sb;
  int             idle_pct;
  int             stuck_cycles;

  // Region as last programmed, used to aim random cells at its edges
  int          aim_xl, aim_xh, aim_yl, aim_yh;
  int unsigned aim_r;

  always #6 clk = ~clk;

  // Result side: random backpressure, check every transaction
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_fill(out_ch.data);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic rfc_in_t make_cell(logic [31:0] vxl, logic [31:0] vxh, logic [31:0] vyl,
                                        logic [31:0] vyh, logic [31:0] cx, logic [31:0] cy,
                                        logic [31:0] e, logic [31:0] d, logic interior);
    rfc_in_t c;
    c.vertex_x_low    = vxl;
    c.vertex_x_high   = vxh;
    c.vertex_y_low    = vyl;
    c.vertex_y_high   = vyh;
    c.centre_x        = cx;
    c.centre_y        = cy;
    c.current_energy  = e;
    c.current_density = d;
    c.interior_cell   = interior;
    return c;
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 2))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      default: return 32'h0;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 32'h0004_0000);
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0;
    endcase
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return pick_extreme();
      default: return int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  // Land on, next to, or near edge a or edge b, or anywhere
  function automatic int near_edge(int a, int b);
    int base;
    base = $urandom_range(0, 1) ? a : b;
    case ($urandom_range(0, 3))
      0:       return base;
      1:       return base + int'($urandom_range(0, 4)) - 2;
      2:       return base + int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Scatter a centre coordinate over the circle and a little past it
  function automatic int around_centre(int base);
    int unsigned off;
    off = $urandom_range(0, aim_r + (aim_r >> 3) + 2);
    return $urandom_range(0, 1) ? base + int'(off) : base - int'(off);
  endfunction

  function automatic rfc_in_t random_cell();
    rfc_in_t c;
    c = make_cell(near_edge(aim_xl, aim_xh), near_edge(aim_xl, aim_xh),
                  near_edge(aim_yl, aim_yh), near_edge(aim_yl, aim_yh),
                  around_centre(aim_xl), around_centre(aim_yl),
                  pick_value(), pick_value(), $urandom_range(0, 3) != 0);
    if ($urandom_range(0, 1)) c.vertex_x_low = aim_xl;
    if ($urandom_range(0, 1)) c.vertex_y_low = aim_yl;
    case ($urandom_range(0, 7))
      0: begin
        // sit exactly on the circle edge
        c.centre_x = aim_xl + int'(aim_r);
        c.centre_y = aim_yl;
      end
      1: begin
        // pure noise
        c = make_cell($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom_range(0, 1));
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_cell(input rfc_in_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_cell(c);
  endtask

  task automatic load_reg(input rfc_cfg_idx_t idx, input logic [31:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // Drop valid and wait until every cell in flight has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_fills.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Program a whole region while the pipeline is empty
  task automatic set_region(input rfc_shape_t shp, input logic [31:0] xl, input logic [31:0] xh,
                            input logic [31:0] yl, input logic [31:0] yh, input logic [31:0] r,
                            input logic [31:0] fe, input logic [31:0] fd);
    logic [31:0] shape_word;
    drain();
    shape_word      = $urandom;
    shape_word[1:0] = shp;
    load_reg(CFG_REGION_SHAPE, shape_word);
    load_reg(CFG_REGION_X_LOW, xl);
    load_reg(CFG_REGION_X_HIGH, xh);
    load_reg(CFG_REGION_Y_LOW, yl);
    load_reg(CFG_REGION_Y_HIGH, yh);
    load_reg(CFG_REGION_RADIUS, r);
    load_reg(CFG_FILL_ENERGY, fe);
    load_reg(CFG_FILL_DENSITY, fd);
    cfg_ch.valid <= 1'b0;
    aim_xl = xl;
    aim_xh = xh;
    aim_yl = yl;
    aim_yh = yh;
    aim_r  = r[30:0];
    // let the derived radius square and fill product settle
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rfc_shape_t shp;
    logic [31:0] r;
    sb           = new();
    idle_pct     = 18;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_REGION_SHAPE;
    cfg_ch.wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset region fills every cell with zero and writes no u
    send_cell(make_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1));
    send_cell(make_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));

    // Rectangle: touching the low edge hits, touching the high edge misses
    set_region(SHAPE_RECT, -ONE, 2 * ONE, -ONE, 2 * ONE, 32'h0, 2 * ONE, 3 * ONE);
    send_cell(make_cell(-3 * ONE, -ONE, -3 * ONE, -ONE, 0, 0, 0, 0, 1'b1));
    send_cell(make_cell(2 * ONE, 3 * ONE, 0, ONE, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_cell(make_cell(0, ONE, 2 * ONE, 3 * ONE, 0, 0, ONE, 5 * ONE, 1'b1));
    send_cell(make_cell(0, ONE, 0, ONE, 0, 0, 7, 9, 1'b0));
    send_cell(make_cell(0, ONE, -3 * ONE, -ONE - 1, 0, 0, 32'h8000, 3, 1'b1));

    // Inverted rectangle is taken as given
    set_region(SHAPE_RECT, ONE, -ONE, ONE, -ONE, 32'h0, 32'hFFFF_FFFF, 32'h1);
    send_cell(make_cell(-2 * ONE, 2 * ONE, -2 * ONE, 2 * ONE, 0, 0, 1, 1, 1'b1));
    send_cell(make_cell(0, 0, 0, 0, 0, 0, ONE, ONE, 1'b1));

    // Circle of radius 5: 3-4-5 lies on the edge, one step further misses
    set_region(SHAPE_CIRCLE, ONE, 0, -ONE, 0, 5 * ONE, 3 * ONE, ONE);
    send_cell(make_cell(0, 0, 0, 0, 4 * ONE, 3 * ONE, 0, 0, 1'b1));
    send_cell(make_cell(0, 0, 0, 0, 4 * ONE, 3 * ONE + 1, 2 * ONE, 2 * ONE, 1'b1));
    send_cell(make_cell(0, 0, 0, 0, -4 * ONE, -ONE, 0, 0, 1'b0));

    // Widest circle at the corner of the coordinate range; bit 31 of radius is dropped
    set_region(SHAPE_CIRCLE, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF,
               32'h0001_8000, 32'h0002_0000);
    send_cell(make_cell(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 5, 6, 1'b1));
    send_cell(make_cell(0, 0, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 5, 6, 1'b1));
    send_cell(make_cell(0, 0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 5, 6, 1'b0));

    // Point: both low vertices must match exactly
    set_region(SHAPE_POINT, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, ONE, ONE);
    send_cell(make_cell(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 1'b1));
    send_cell(make_cell(32'h7FFF_FFFF, 0, 32'h8000_0001, 0, 0, 0, 3, 4, 1'b1));

    // Fill-all with saturating fill values still writes no u
    set_region(SHAPE_FILL_ALL, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cell(make_cell(0, ONE, 0, ONE, 0, 0, 1, 1, 1'b1));

    // Random regions, every shape twice, two of them with no idling at all
    for (int p = 0; p < 8; p++) begin
      shp = rfc_shape_t'(p % 4);
      case ($urandom_range(0, 3))
        0:       r = 32'hFFFF_FFFF;
        1:       r = $urandom_range(0, 1) << 31;
        default: r = $urandom_range(0, 32'h0008_0000) | ($urandom_range(0, 1) << 31);
      endcase
      set_region(shp, pick_coord(), pick_coord(), pick_coord(), pick_coord(), r,
                 pick_value(), pick_value());
      idle_pct = (p == 2 || p == 5) ? 0 : 18;
      for (int n = 0; n < 55; n++) begin
        send_cell(random_cell());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.fails == 0 && sb.pending_fills.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
